// ===== rtl/wsh_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package wsh_pkg;

	localparam int unsigned PERIOD_W   = 16;
	localparam int unsigned PULSE_W    = 24;
	localparam int unsigned SPEED_W    = 26;
	localparam int unsigned RPM_W      = 16;
	localparam int unsigned DIST_W     = 40;
	localparam int unsigned CFG_W      = 16;
	localparam int unsigned CFG_IDX_W  = 1;

	localparam logic [PERIOD_W-1:0] TICK_MS       = 16'd1;
	localparam logic [PERIOD_W-1:0] PERIOD_MAX    = 16'hFFFF;
	localparam logic [CFG_W-1:0]    PERIMETER_RST = 16'd2073;
	localparam logic [CFG_W-1:0]    STALL_RST     = 16'd2000;
	localparam logic [9:0]          MM_PER_M      = 10'd1000;
	localparam logic [SPEED_W-1:0]  RPM_NUMER     = 26'd60000;

	localparam int unsigned DIV_STEPS = SPEED_W;
	localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

	localparam int unsigned QUEUE_DEPTH = 2;
	localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

	localparam logic [CFG_IDX_W-1:0] CFG_PERIMETER = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_STALL     = 1'd1;

	typedef enum logic [1:0] {
		EV_FIRST = 2'd0,
		EV_REV   = 2'd1,
		EV_STALL = 2'd2
	} event_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_DIV,
		B_DONE
	} back_state_t;

	typedef struct packed {
		logic hall_level;
	} in_item_t;

	typedef struct packed {
		logic [1:0]          event_code;
		logic [PULSE_W-1:0]  pulse_count;
		logic [PERIOD_W-1:0] period_ms;
		logic [SPEED_W-1:0]  speed_mm_s;
		logic [RPM_W-1:0]    rev_per_min;
		logic [DIST_W-1:0]   distance_mm;
	} out_item_t;

	typedef struct packed {
		event_t              event_code;
		logic [PULSE_W-1:0]  pulse_count;
		logic [PERIOD_W-1:0] period_ms;
		logic [SPEED_W-1:0]  dividend;
		logic [DIST_W-1:0]   distance_mm;
	} job_t;

	typedef struct packed {
		logic push;
		job_t job;
	} push_t;

	typedef struct packed {
		logic empty;
		job_t job;
	} pop_t;

endpackage
`default_nettype wire

// ===== rtl/wsh_stream_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface wsh_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== rtl/wheel_speed_from_hall_pulses.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Wheel speedometer fed one active-low hall sample per millisecond tick. A
// sample that produces no result only updates the front's registers. A sample
// that ends a revolution is queued, and its speed and rpm are worked out by a
// bit-serial restoring divider; the back end pops it from the queue, runs the
// division and then loads the output register, and takes the next job only
// once that result has been loaded. First-detection and stall results need no
// division and go from the queue straight to the output register. A two-entry
// queue lets the front keep taking samples while the divider runs, so the
// input stalls only when two results are already waiting. After a stall stop
// the block ignores all samples until reset. Configuration writes take effect
// at once and are meant to be made while no transaction is in flight.
module wheel_speed_from_hall_pulses import wsh_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	wsh_stream_if.sink                 hall,
	wsh_stream_if.source               result,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_W-1:0]      cfg_data
);

	logic [CFG_W-1:0] perimeter_q;
	logic [CFG_W-1:0] stall_q;
	push_t            push;
	pop_t             head;
	logic             pop;
	logic             full;
	logic             accept;
	out_item_t        out_item;

	assign hall.ready     = !full;
	assign accept         = hall.valid && !full;
	assign result.payload = out_item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			perimeter_q <= PERIMETER_RST;
			stall_q     <= STALL_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_PERIMETER: perimeter_q <= cfg_data;
				CFG_STALL:     stall_q     <= cfg_data;
				default:       perimeter_q <= perimeter_q;
			endcase
		end
	end

	wsh_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.accept         (accept),
		.hall_level     (hall.payload.hall_level),
		.perimeter_mm   (perimeter_q),
		.stall_limit_ms (stall_q),
		.push           (push)
	);

	wsh_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.head   (head),
		.full   (full)
	);

	wsh_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.pop       (pop),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.out_item  (out_item)
	);

endmodule
`default_nettype wire

// ===== rtl/wsh_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module wsh_front import wsh_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                accept,
	input  wire logic                hall_level,
	input  wire logic [CFG_W-1:0]    perimeter_mm,
	input  wire logic [CFG_W-1:0]    stall_limit_ms,
	output push_t                    push
);

	logic                started_q;
	logic                gap_seen_q;
	logic                halted_q;
	logic [PERIOD_W-1:0] period_q;
	logic [PULSE_W-1:0]  detections_q;
	logic [DIST_W-1:0]   travelled_q;

	logic [PERIOD_W:0]   period_sum;
	logic [PERIOD_W-1:0] period_next;
	logic                detect;
	logic [PULSE_W-1:0]  detections_inc;
	logic [DIST_W-1:0]   travelled_inc;
	logic [SPEED_W-1:0]  dividend;

	assign detect         = !hall_level;
	assign period_sum     = {1'b0, period_q} + {1'b0, TICK_MS};
	assign period_next    = !started_q ? period_q :
	                        period_sum[PERIOD_W] ? PERIOD_MAX : period_sum[PERIOD_W-1:0];
	assign detections_inc = detections_q + PULSE_W'(1);
	assign travelled_inc  = travelled_q + DIST_W'(perimeter_mm);
	assign dividend       = SPEED_W'(perimeter_mm) * SPEED_W'(MM_PER_M);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q    <= 1'b0;
			gap_seen_q   <= 1'b0;
			halted_q     <= 1'b0;
			period_q     <= '0;
			detections_q <= '0;
			travelled_q  <= '0;
		end else if (accept && !halted_q) begin
			if (!detect) begin
				gap_seen_q <= 1'b1;
				period_q   <= period_next;
			end else if (!started_q) begin
				started_q    <= 1'b1;
				gap_seen_q   <= 1'b0;
				period_q     <= '0;
				detections_q <= detections_inc;
			end else if (!gap_seen_q) begin
				period_q <= period_next;
			end else begin
				gap_seen_q   <= 1'b0;
				detections_q <= detections_inc;
				if (period_next > stall_limit_ms) begin
					halted_q <= 1'b1;
					period_q <= period_next;
				end else begin
					travelled_q <= travelled_inc;
					period_q    <= '0;
				end
			end
		end
	end

	always_comb begin
		push.push            = 1'b0;
		push.job.event_code  = EV_FIRST;
		push.job.pulse_count = detections_inc;
		push.job.period_ms   = '0;
		push.job.dividend    = '0;
		push.job.distance_mm = travelled_q;
		if (accept && !halted_q && detect) begin
			if (!started_q) begin
				push.push = 1'b1;
			end else if (gap_seen_q) begin
				push.push          = 1'b1;
				push.job.period_ms = period_next;
				if (period_next > stall_limit_ms) begin
					push.job.event_code = EV_STALL;
				end else begin
					push.job.event_code  = EV_REV;
					push.job.dividend    = dividend;
					push.job.distance_mm = travelled_inc;
				end
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/wsh_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
module wsh_queue import wsh_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire push_t push,
	input  wire logic  pop,
	output pop_t       head,
	output logic       full
);

	job_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;
	logic              do_push;
	logic              do_pop;

	assign full       = count_q == (QPTR_W+1)'(QUEUE_DEPTH);
	assign head.empty = count_q == '0;
	assign head.job   = mem_q[rd_ptr_q];
	assign do_push    = push.push && !full;
	assign do_pop     = pop && !head.empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push.job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + (QPTR_W+1)'(1);
				2'b01:   count_q <= count_q - (QPTR_W+1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== rtl/wsh_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
module wsh_back import wsh_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire pop_t  head,
	output logic       pop,
	output logic       out_valid,
	input  wire logic  out_ready,
	output out_item_t  out_item
);

	back_state_t          state_q;
	back_state_t          state_next;
	job_t                 job_q;
	logic [PERIOD_W-1:0]  divisor_q;
	logic [SPEED_W-1:0]   spd_dvd_q;
	logic [PERIOD_W-1:0]  spd_rem_q;
	logic [SPEED_W-1:0]   rpm_dvd_q;
	logic [PERIOD_W-1:0]  rpm_rem_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 out_valid_q;
	out_item_t            out_q;

	logic [PERIOD_W:0]    spd_sh;
	logic [PERIOD_W:0]    rpm_sh;
	logic [PERIOD_W:0]    spd_diff;
	logic [PERIOD_W:0]    rpm_diff;
	logic                 spd_ge;
	logic                 rpm_ge;
	logic                 load;
	logic                 last_step;

	assign spd_sh    = {spd_rem_q, spd_dvd_q[SPEED_W-1]};
	assign rpm_sh    = {rpm_rem_q, rpm_dvd_q[SPEED_W-1]};
	assign spd_diff  = spd_sh - {1'b0, divisor_q};
	assign rpm_diff  = rpm_sh - {1'b0, divisor_q};
	assign spd_ge    = spd_sh >= {1'b0, divisor_q};
	assign rpm_ge    = rpm_sh >= {1'b0, divisor_q};
	assign last_step = cnt_q == DIV_CNT_W'(DIV_STEPS - 1);
	assign load      = (state_q == B_DONE) && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	always_comb begin
		state_next = state_q;
		pop        = 1'b0;
		case (state_q)
			B_IDLE: begin
				if (!head.empty) begin
					pop        = 1'b1;
					state_next = (head.job.event_code == EV_REV) ? B_DIV : B_DONE;
				end
			end
			B_DIV: begin
				if (last_step) begin
					state_next = B_DONE;
				end
			end
			B_DONE: begin
				if (load) begin
					state_next = B_IDLE;
				end
			end
			default: state_next = B_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			job_q     <= head.job;
			divisor_q <= (head.job.period_ms == '0) ? PERIOD_W'(1) : head.job.period_ms;
			cnt_q     <= '0;
			spd_rem_q <= '0;
			rpm_rem_q <= '0;
			if (head.job.event_code == EV_REV) begin
				spd_dvd_q <= head.job.dividend;
				rpm_dvd_q <= RPM_NUMER;
			end else begin
				spd_dvd_q <= '0;
				rpm_dvd_q <= '0;
			end
		end else if (state_q == B_DIV) begin
			cnt_q     <= cnt_q + DIV_CNT_W'(1);
			spd_rem_q <= spd_ge ? spd_diff[PERIOD_W-1:0] : spd_sh[PERIOD_W-1:0];
			rpm_rem_q <= rpm_ge ? rpm_diff[PERIOD_W-1:0] : rpm_sh[PERIOD_W-1:0];
			spd_dvd_q <= {spd_dvd_q[SPEED_W-2:0], spd_ge};
			rpm_dvd_q <= {rpm_dvd_q[SPEED_W-2:0], rpm_ge};
		end
		if (load) begin
			out_q.event_code  <= job_q.event_code;
			out_q.pulse_count <= job_q.pulse_count;
			out_q.period_ms   <= job_q.period_ms;
			out_q.speed_mm_s  <= spd_dvd_q;
			out_q.rev_per_min <= rpm_dvd_q[RPM_W-1:0];
			out_q.distance_mm <= job_q.distance_mm;
		end
	end

endmodule
`default_nettype wire

// ===== sim/speedometer_checker.sv =====
`timescale 1ns / 1ps
module speedometer_checker import wsh_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 hall_valid,
	input  logic                 hall_ready,
	input  in_item_t             hall_item,
	input  logic                 result_valid,
	input  logic                 result_ready,
	input  out_item_t            result_item,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	output int                   mismatches,
	output int                   outstanding,
	output int                   compared
);

	logic [CFG_W-1:0]    perimeter;
	logic [CFG_W-1:0]    stall_limit;
	logic                started;
	logic                gap_seen;
	logic                halted;
	logic [PERIOD_W-1:0] period_count;
	logic [PULSE_W-1:0]  detections;
	logic [DIST_W-1:0]   travelled;
	out_item_t           expected_q[$];

	function automatic out_item_t make_result(input event_t code,
			input logic [PERIOD_W-1:0] period, input logic [63:0] speed,
			input logic [63:0] rpm);
		out_item_t r;
		r.event_code  = code;
		r.pulse_count = detections;
		r.period_ms   = period;
		r.speed_mm_s  = speed[SPEED_W-1:0];
		r.rev_per_min = rpm[RPM_W-1:0];
		r.distance_mm = travelled;
		return r;
	endfunction

	task automatic track_sample(input logic level);
		logic [PERIOD_W:0]   sum;
		logic [PERIOD_W-1:0] period;
		logic [63:0]         divisor;
		logic [63:0]         speed;
		logic [63:0]         rpm;
		if (!halted) begin
			if (started) begin
				sum = {1'b0, period_count} + TICK_MS;
				period_count = sum[PERIOD_W] ? PERIOD_MAX : sum[PERIOD_W-1:0];
			end
			if (level) begin
				gap_seen = 1'b1;
			end else if (!started) begin
				started = 1'b1;
				gap_seen = 1'b0;
				period_count = '0;
				detections = detections + 1'b1;
				expected_q.push_back(make_result(EV_FIRST, '0, '0, '0));
			end else if (gap_seen) begin
				gap_seen = 1'b0;
				period = period_count;
				detections = detections + 1'b1;
				if (period > stall_limit) begin
					halted = 1'b1;
					expected_q.push_back(make_result(EV_STALL, period, '0, '0));
				end else begin
					divisor = (period == '0) ? 64'd1 : 64'(period);
					speed = (64'(perimeter) * 64'd1000) / divisor;
					rpm = 64'd60000 / divisor;
					travelled = travelled + perimeter;
					expected_q.push_back(make_result(EV_REV, period, speed, rpm));
					period_count = '0;
				end
			end
		end
	endtask

	task automatic compare_result(input out_item_t got);
		out_item_t want;
		logic      bad;
		if (expected_q.size() == 0) begin
			if (mismatches < 10)
				$display("Unexpected result: event %0d pulses %0d period %0d speed %0d rpm %0d distance %0d",
					got.event_code, got.pulse_count, got.period_ms, got.speed_mm_s,
					got.rev_per_min, got.distance_mm);
			mismatches++;
		end else begin
			want = expected_q.pop_front();
			compared++;
			bad = (got.event_code !== want.event_code)
				|| (got.pulse_count !== want.pulse_count)
				|| (got.period_ms !== want.period_ms)
				|| (got.speed_mm_s !== want.speed_mm_s)
				|| (got.rev_per_min !== want.rev_per_min)
				|| (got.distance_mm !== want.distance_mm);
			if (bad) begin
				if (mismatches < 10) begin
					$display("Mismatch in result %0d, expected: event %0d pulses %0d period %0d speed %0d rpm %0d distance %0d",
						compared, want.event_code, want.pulse_count, want.period_ms,
						want.speed_mm_s, want.rev_per_min, want.distance_mm);
					$display("  actual: event %0d pulses %0d period %0d speed %0d rpm %0d distance %0d",
						got.event_code, got.pulse_count, got.period_ms, got.speed_mm_s,
						got.rev_per_min, got.distance_mm);
				end
				mismatches++;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			perimeter = PERIMETER_RST;
			stall_limit = STALL_RST;
			started = 1'b0;
			gap_seen = 1'b0;
			halted = 1'b0;
			period_count = '0;
			detections = '0;
			travelled = '0;
			expected_q.delete();
			outstanding = 0;
		end else begin
			if (result_valid && result_ready)
				compare_result(result_item);
			if (cfg_we) begin
				case (cfg_index)
					CFG_PERIMETER: perimeter = cfg_data;
					CFG_STALL:     stall_limit = cfg_data;
					default:       ;
				endcase
			end
			if (hall_valid && hall_ready)
				track_sample(hall_item.hall_level);
			outstanding = expected_q.size();
		end
	end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
	import wsh_pkg::*;

	localparam int SETTLE_CYCLES  = 64;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int PHASE_ITEMS    = 270;
	localparam int STALL_GAP      = 40;
	localparam logic [CFG_W-1:0] FINAL_STALL = 16'd30;
	localparam logic [13:0] OPENING = 14'b11000101011101;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_PERIMETER;
	logic [CFG_W-1:0]     cfg_data = '0;
	logic                 calm = 1'b0;
	logic [CFG_W-1:0]     stall_limit_now = STALL_RST;
	int                   samples_sent = 0;
	int                   settings_used = 1;
	int                   quiet_cycles = 0;
	int                   mismatches;
	int                   outstanding;
	int                   compared;

	wsh_stream_if #(.payload_t(in_item_t))  hall_ch ();
	wsh_stream_if #(.payload_t(out_item_t)) result_ch ();

	wheel_speed_from_hall_pulses u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.hall      (hall_ch),
		.result    (result_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	speedometer_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.hall_valid   (hall_ch.valid),
		.hall_ready   (hall_ch.ready),
		.hall_item    (hall_ch.payload),
		.result_valid (result_ch.valid),
		.result_ready (result_ch.ready),
		.result_item  (result_ch.payload),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.mismatches   (mismatches),
		.outstanding  (outstanding),
		.compared     (compared)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		result_ch.ready <= calm || ($urandom_range(99) >= 8);
	end

	always @(posedge clk) begin
		if ((hall_ch.valid && hall_ch.ready) || (result_ch.valid && result_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("testbench failed");
			$finish;
		end
	end

	task automatic send_sample(input logic level);
		if (!calm && $urandom_range(99) < 8) begin
			hall_ch.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < 8);
		end
		hall_ch.valid <= 1'b1;
		hall_ch.payload.hall_level <= level;
		do @(posedge clk); while (!hall_ch.ready);
		samples_sent++;
	endtask

	// A detect run followed by a gap; noisy ones flip inner samples at random, which only
	// shortens periods, so the length bounds every period that the segment produces.
	task automatic send_segment(input int length, input logic noisy);
		int   run;
		logic level;
		run = int'($urandom_range(length - 1, 1));
		for (int i = 0; i < length; i++) begin
			if (i == 0)
				level = 1'b0;
			else if (i == length - 1)
				level = 1'b1;
			else if (noisy)
				level = 1'($urandom_range(1, 0));
			else
				level = (i >= run);
			send_sample(level);
		end
	endtask

	task automatic settle();
		hall_ch.valid <= 1'b0;
		@(posedge clk);
		wait (outstanding == 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [CFG_W-1:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= index;
		cfg_data <= value;
		if (index == CFG_STALL)
			stall_limit_now = value;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic configure(input logic [CFG_W-1:0] perimeter, input logic [CFG_W-1:0] stall);
		settle();
		write_reg(CFG_PERIMETER, perimeter);
		write_reg(CFG_STALL, stall);
		settings_used++;
	endtask

	task automatic random_phase(input int budget);
		int start;
		int length;
		int short_max;
		start = samples_sent;
		short_max = (stall_limit_now < 30) ? int'(stall_limit_now) : 30;
		while (samples_sent - start < budget) begin
			if ($urandom_range(99) < 10)
				length = (stall_limit_now <= 400) ? int'(stall_limit_now)
					: int'($urandom_range(400, 31));
			else
				length = int'($urandom_range(short_max, 2));
			send_segment(length, $urandom_range(99) < 15);
		end
		// A short closing revolution keeps the first period under the next setting small.
		send_segment(2, 1'b0);
	endtask

	initial begin
		hall_ch.valid = 1'b0;
		hall_ch.payload = '0;
		result_ch.ready = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		for (int i = 13; i >= 0; i--)
			send_sample(OPENING[i]);

		configure(16'd1, 16'd2);
		random_phase(PHASE_ITEMS / 2);
		configure(16'd65535, 16'd65534);
		random_phase(PHASE_ITEMS);
		configure(CFG_W'($urandom_range(65535, 1)), CFG_W'($urandom_range(60, 20)));
		calm = 1'b1;
		random_phase(PHASE_ITEMS);
		calm = 1'b0;
		configure(CFG_W'($urandom_range(65535, 1)), STALL_RST);
		random_phase(PHASE_ITEMS);
		configure(CFG_W'($urandom_range(65535, 1)), CFG_W'($urandom_range(400, 61)));
		random_phase(PHASE_ITEMS);

		// A gap longer than the stall limit ends in a stall stop; later samples must be
		// ignored.
		configure(CFG_W'($urandom_range(65535, 1)), FINAL_STALL);
		send_sample(1'b0);
		repeat (STALL_GAP) send_sample(1'b1);
		send_sample(1'b0);
		repeat (8) send_sample(1'($urandom_range(1, 0)));
		settle();

		$display("Sent %0d hall samples under %0d register settings, from single ticks to a stall stop.",
			samples_sent, settings_used);
		$display("Compared %0d results, %0d of them failed.", compared, mismatches);
		if (mismatches == 0 && outstanding == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/wsh_pkg.sv
rtl/wsh_stream_if.sv
rtl/wsh_front.sv
rtl/wsh_queue.sv
rtl/wsh_back.sv
rtl/wheel_speed_from_hall_pulses.sv
sim/speedometer_checker.sv
sim/testbench.sv
